### src/lz_pkg.sv
// Shared types and constants for the LZ78 stream compressor
`timescale 1ns / 1ps
`default_nettype none
package lz_pkg;

  localparam int DICT_ENTRIES_DEF = 4096;
  localparam int IDX_W            = 12;
  localparam int BYTE_W           = 8;
  localparam logic [IDX_W-1:0] MAX_ENTRIES_RST = 12'd4095;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              stream_end;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  prefix_index;
    logic [BYTE_W-1:0] next_byte;
    logic              has_byte;
    logic              last_pair;
  } result_t;

endpackage
`default_nettype wire

### src/lz_if.sv
// Input and output stream interfaces
`timescale 1ns / 1ps
`default_nettype none
interface lz_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;
  modport source (output valid, output data_byte, output stream_end, input ready);
  modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface lz_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] prefix_index;
  logic [7:0]  next_byte;
  logic        has_byte;
  logic        last_pair;
  modport source (output valid, output prefix_index, output next_byte, output has_byte,
                  output last_pair, input ready);
  modport sink   (input valid, input prefix_index, input next_byte, input has_byte,
                  input last_pair, output ready);
endinterface
`default_nettype wire

### src/lz78_stream_compressor.sv
// LZ78 stream compressor top level
//
// items: one beat per input byte (data_byte, stream_end), valid/ready.
// results: (prefix_index, next_byte, has_byte, last_pair) beats, valid/ready.
// cfg_we/cfg_wdata write max_entries (highest index assigned), reset 4095.
// A byte that extends the current phrase gives no beat; a miss gives one pair
// and adds an entry while growth is allowed; stream_end flushes a pending
// phrase with has_byte clear and empties the dictionary.
// In the engine each byte goes through a slot read, an entry read and a
// compare, again for every extra probe of the hashed slot table; a miss or a
// flush then hands over a result from the emit state, and no new byte is taken
// until that is done. A result is registered in the output queue before it
// leaves the block. Two-beat queues sit on both channels, so the source and
// the sink stall each other only when those fill. After rst the slot table is
// cleared slot by slot, during which the engine takes no byte and the input
// queue holds at most two beats; config writes are taken.
`timescale 1ns / 1ps
`default_nettype none
module lz78_stream_compressor
  import lz_pkg::*;
#(
  parameter int DICT_ENTRIES = DICT_ENTRIES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_wdata,
  lz_in_if.sink                 items,
  lz_out_if.source              results
);
  localparam int IT_W  = $bits(item_t);
  localparam int RES_W = $bits(result_t);

  item_t   q_item;
  logic    q_valid;
  logic    q_ready;
  result_t e_res;
  logic    e_valid;
  logic    e_ready;
  result_t o_res;

  lz_fifo #(.WIDTH(IT_W)) u_front (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (items.valid),
    .wr_ready (items.ready),
    .wr_data  ({items.data_byte, items.stream_end}),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_item)
  );

  lz_engine #(.DICT_ENTRIES(DICT_ENTRIES)) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .res_valid  (e_valid),
    .res_ready  (e_ready),
    .res        (e_res)
  );

  lz_fifo #(.WIDTH(RES_W)) u_back (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (e_valid),
    .wr_ready (e_ready),
    .wr_data  (e_res),
    .rd_valid (results.valid),
    .rd_ready (results.ready),
    .rd_data  (o_res)
  );

  assign results.prefix_index = o_res.prefix_index;
  assign results.next_byte    = o_res.next_byte;
  assign results.has_byte     = o_res.has_byte;
  assign results.last_pair    = o_res.last_pair;
endmodule
`default_nettype wire

### src/lz_fifo.sv
// Two-entry beat queue
`timescale 1ns / 1ps
`default_nettype none
module lz_fifo #(
  parameter int WIDTH = 9
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output logic [WIDTH-1:0]      rd_data
);
  logic [WIDTH-1:0] slots [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = slots[rptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

### src/lz_engine.sv
// Dictionary engine: hashed slot table plus entry memory, one probe per pass
`timescale 1ns / 1ps
`default_nettype none
module lz_engine
  import lz_pkg::*;
#(
  parameter int DICT_ENTRIES = DICT_ENTRIES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_wdata,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire item_t            item,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output result_t               res
);
  localparam int IW = $clog2(DICT_ENTRIES);
  localparam int SW = IW + 1;           // slot table has twice the entries
  localparam int HK = IW + BYTE_W;
  localparam int CW = IW + IDX_W + 1;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RDH  = 3'd2;
  localparam logic [2:0] S_RDD  = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  typedef struct packed {
    logic [IW-1:0]     parent;
    logic [BYTE_W-1:0] symbol;
    logic [SW-1:0]     home;
  } entry_t;

  logic [IW-1:0]     hmem [2**SW];
  entry_t            dmem [DICT_ENTRIES];

  logic [2:0]        state;
  logic [IDX_W-1:0]  max_entries;
  logic [IW-1:0]     prefix;
  logic [IW:0]       nfree;
  logic [SW-1:0]     slot;
  logic [BYTE_W-1:0] cur_byte;
  logic              cur_end;
  logic [IW-1:0]     hq;
  entry_t            dq;

  logic [HK-1:0]     hkey;
  logic [SW-1:0]     hash;
  logic [CW-1:0]     lim;
  logic [CW-1:0]     nf_ext;
  logic [CW-1:0]     cap;
  logic [CW-1:0]     me_ext;
  logic              grow;
  logic              slot_live;
  logic              key_match;
  logic [IW+IDX_W-1:0] hq_ext;
  logic [IW+IDX_W-1:0] pf_ext;

  assign hkey   = {item.data_byte, prefix};
  assign hash   = hkey[SW-1:0] ^ SW'(hkey >> SW);
  assign me_ext = {{(CW-IDX_W){1'b0}}, max_entries};
  assign cap    = CW'(DICT_ENTRIES - 1);
  assign lim    = (me_ext > cap) ? cap : me_ext;
  assign nf_ext = {{(CW-IW-1){1'b0}}, nfree};
  assign grow   = (nf_ext <= lim);
  // a slot counts only if its entry is live and points back at it
  assign slot_live = (hq != '0) && ({1'b0, hq} < nfree) && (dq.home == slot);
  assign key_match = (dq.parent == prefix) && (dq.symbol == cur_byte);
  assign hq_ext = {{IDX_W{1'b0}}, hq};
  assign pf_ext = {{IDX_W{1'b0}}, prefix};

  assign item_ready = (state == S_IDLE);
  assign res_valid  = (state == S_EMIT);

  always_ff @(posedge clk) begin
    if (state == S_CLR) begin
      hmem[slot] <= '0;
    end else if (state == S_CHK && !(slot_live && key_match) && !slot_live && grow) begin
      hmem[slot] <= nfree[IW-1:0];
    end
    hq <= hmem[slot];
  end

  always_ff @(posedge clk) begin
    if (state == S_CHK && !slot_live && grow) begin
      dmem[nfree[IW-1:0]] <= '{parent: prefix, symbol: cur_byte, home: slot};
    end
    dq <= dmem[hq];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      max_entries <= MAX_ENTRIES_RST;
      prefix      <= '0;
      nfree       <= (IW+1)'(1);
      slot        <= '0;
    end else begin
      if (cfg_we) max_entries <= cfg_wdata;
      case (state)
        S_CLR: begin
          slot <= slot + 1'b1;
          if (slot == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (item_valid) begin
            cur_byte <= item.data_byte;
            cur_end  <= item.stream_end;
            slot     <= hash;
            state    <= S_RDH;
          end
        end
        S_RDH: state <= S_RDD;
        S_RDD: state <= S_CHK;
        S_CHK: begin
          if (slot_live && key_match) begin
            if (cur_end) begin
              res    <= '{prefix_index: hq_ext[IDX_W-1:0], next_byte: '0,
                          has_byte: 1'b0, last_pair: 1'b1};
              prefix <= '0;
              nfree  <= (IW+1)'(1);
              state  <= S_EMIT;
            end else begin
              prefix <= hq;
              state  <= S_IDLE;
            end
          end else if (slot_live) begin
            slot  <= slot + 1'b1;
            state <= S_RDH;
          end else begin
            res    <= '{prefix_index: pf_ext[IDX_W-1:0], next_byte: cur_byte,
                        has_byte: 1'b1, last_pair: cur_end};
            prefix <= '0;
            if (cur_end)   nfree <= (IW+1)'(1);
            else if (grow) nfree <= nfree + 1'b1;
            state  <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (res_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### bench/lz78_stream_compressor_test.sv
// Testbench for the LZ78 stream compressor: predicts pairs and checks every result beat
`timescale 1ns / 1ps
module lz78_stream_compressor_test;
  import lz_pkg::*;

  localparam int DICT_N    = DICT_ENTRIES_DEF;
  localparam int WDOG_MAX  = 20000;
  localparam int ENGINE_LAT = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_wdata = '0;

  lz_in_if  items();
  lz_out_if results();

  lz78_stream_compressor u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .items    (items.sink),
    .results  (results.source)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [IDX_W-1:0]  phrase_parent [DICT_N];
  logic [BYTE_W-1:0] phrase_sym    [DICT_N];
  int unsigned       free_idx;
  logic [IDX_W-1:0]  cur_phrase;
  logic [IDX_W-1:0]  max_ent;

  result_t pending_pairs[$];
  int      n_errors = 0;
  int      idle_cycles = 0;
  bit      quiet = 1'b0;   // no idling in the closing part
  int      sink_gap = 0;

  initial begin
    items.valid      = 1'b0;
    items.data_byte  = '0;
    items.stream_end = 1'b0;
    results.ready    = 1'b0;
  end

  function automatic int unsigned find_phrase(logic [IDX_W-1:0] par, logic [BYTE_W-1:0] b);
    for (int unsigned i = 1; i < free_idx && i < DICT_N; i++)
      if (phrase_parent[i] == par && phrase_sym[i] == b) return i;
    return 0;
  endfunction

  task automatic encode_byte(logic [BYTE_W-1:0] b, logic last);
    int unsigned hit;
    int unsigned lim;
    result_t r;
    hit = find_phrase(cur_phrase, b);
    lim = (max_ent > DICT_N - 1) ? DICT_N - 1 : max_ent;
    if (hit != 0) begin
      cur_phrase = IDX_W'(hit);
      if (last) begin
        r = '{prefix_index: cur_phrase, next_byte: '0, has_byte: 1'b0, last_pair: 1'b1};
        pending_pairs.push_back(r);
      end
    end else begin
      r = '{prefix_index: cur_phrase, next_byte: b, has_byte: 1'b1, last_pair: last};
      pending_pairs.push_back(r);
      if (free_idx <= lim) begin
        phrase_parent[free_idx] = cur_phrase;
        phrase_sym[free_idx]    = b;
        free_idx++;
      end
      cur_phrase = '0;
    end
    if (last) begin
      free_idx   = 1;
      cur_phrase = '0;
    end
  endtask

  // sends one byte, with an optional random gap first; valid drops at the gap
  // or in drain(), so back-to-back beats never touch valid twice in one step
  task automatic send_byte(logic [BYTE_W-1:0] b, logic last);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      items.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    items.valid      <= 1'b1;
    items.data_byte  <= b;
    items.stream_end <= last;
    do @(posedge clk); while (!(items.valid && items.ready));
    encode_byte(b, last);
  endtask

  task automatic drain();
    items.valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (ENGINE_LAT) @(posedge clk);
  endtask

  task automatic set_max_entries(logic [IDX_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    max_ent = v;
  endtask

  // sink side: random stalls in bursts of random length
  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
      sink_gap      <= 0;
    end else if (quiet) begin
      results.ready <= 1'b1;
    end else if (sink_gap != 0) begin
      results.ready <= 1'b0;
      sink_gap      <= sink_gap - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      results.ready <= 1'b0;
      sink_gap      <= $urandom_range(0, 16);
    end else begin
      results.ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && results.valid && results.ready) begin
      if (pending_pairs.size() == 0) begin
        $error("unexpected beat prefix_index=%0d", results.prefix_index);
        n_errors++;
      end else begin
        want = pending_pairs.pop_front();
        if (results.prefix_index !== want.prefix_index) begin
          $error("prefix_index exp %0d got %0d", want.prefix_index, results.prefix_index);
          n_errors++;
        end
        if (results.next_byte !== want.next_byte) begin
          $error("next_byte exp %0h got %0h", want.next_byte, results.next_byte);
          n_errors++;
        end
        if (results.has_byte !== want.has_byte) begin
          $error("has_byte exp %0b got %0b", want.has_byte, results.has_byte);
          n_errors++;
        end
        if (results.last_pair !== want.last_pair) begin
          $error("last_pair exp %0b got %0b", want.last_pair, results.last_pair);
          n_errors++;
        end
      end
    end
  end

  // watchdog: counts cycles without any beat; allows for the slot table clear
  always @(posedge clk) begin
    if ((items.valid && items.ready) || (results.valid && results.ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_MAX + 2 * DICT_N) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic test_directed();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);   // hit, then extend
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);   // hit on the last byte: flush
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);   // miss on the last byte
    send_byte(8'h3C, 1'b1);   // single-byte stream
    send_byte(8'h3C, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'h3C, 1'b1);
  endtask

  task automatic test_full_dictionary();
    set_max_entries(12'd1);
    for (int i = 0; i < 6; i++) send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b1);
    set_max_entries(12'd0);
    for (int i = 0; i < 4; i++) send_byte(8'h11, i == 3);
    // lower the limit with entries present: they stay searchable
    set_max_entries(12'd4095);
    for (int i = 0; i < 5; i++) send_byte(8'h7E, 1'b0);
    set_max_entries(12'd2);
    for (int i = 0; i < 5; i++) send_byte(8'h7E, i == 4);
  endtask

  // well-formed streams, mostly from a small alphabet so phrases grow long
  task automatic random_streams(int total, logic [IDX_W-1:0] lim);
    int sent;
    int len;
    int alpha;
    logic [BYTE_W-1:0] b;
    set_max_entries(lim);
    sent = 0;
    while (sent < total) begin
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
      alpha = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(1, 4);
      for (int i = 0; i < len; i++) begin
        b = (alpha == 256) ? 8'($urandom) : 8'($urandom_range(0, alpha - 1)) ^ 8'hC3;
        send_byte(b, i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    free_idx   = 1;
    cur_phrase = '0;
    max_ent    = MAX_ENTRIES_RST;
    test_directed();
    test_full_dictionary();
    random_streams(500, 12'd4095);
    random_streams(350, 12'd7);
    random_streams(350, 12'd200);
    quiet = 1'b1;
    random_streams(400, 12'd4095);
    drain();
    if (n_errors == 0 && pending_pairs.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
